>>> rtl/core/srm_pkg.sv
package srm_pkg;

    // fixed field widths
    localparam int PERIOD_W = 24;
    localparam int P13_W    = 28;
    localparam int LIMIT_W  = 8;
    localparam int DIV_W    = 16;
    localparam int CNT_W    = 16;
    localparam int MASK_W   = 3;
    localparam int CLASS_W  = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int NUM_DIV  = 3;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 16;

    // parameter defaults
    localparam int STREAMS_DEF  = 3;
    localparam int AGE_BITS_DEF = 8;

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd10000;
    localparam logic [P13_W-1:0]    PERIOD13_RST = 28'd130000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST    = 8'd10;
    localparam logic [LIMIT_W-1:0]  SAT_RST      = 8'd255;
    localparam logic [DIV_W-1:0]    DIV_RST      = 16'd0;

    typedef enum logic [CLASS_W-1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_OK      = 2'd1,
        CLS_WARN    = 2'd2,
        CLS_ERROR   = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        REG_PERIOD   = 3'd0,
        REG_LIMIT    = 3'd1,
        REG_SAT      = 3'd2,
        REG_DIV_SOL  = 3'd3,
        REG_DIV_IMU  = 3'd4,
        REG_DIV_DEV  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic ok;
        logic lost;
        logic recovered;
    } t_lane_flags;

    typedef struct packed {
        logic [4:0]          pad;
        logic [PERIOD_W-1:0] interval_us;
        logic [MASK_W-1:0]   arrived_mask;
    } t_in_word;

    typedef struct packed {
        logic [3:0]        pad;
        logic [MASK_W-1:0] streams_recovered;
        logic [MASK_W-1:0] streams_lost;
        logic [MASK_W-1:0] streams_ok;
        logic              publish_state_changed;
        t_class            publish_state;
    } t_out_word;

endpackage

>>> rtl/core/srm_lane.sv
module srm_lane #(
    parameter int AGE_BITS = srm_pkg::AGE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_arrived,
    input  logic [srm_pkg::DIV_W-1:0]    i_divider,
    input  logic [srm_pkg::LIMIT_W-1:0]  i_limit,
    input  logic [srm_pkg::LIMIT_W-1:0]  i_sat,
    output srm_pkg::t_lane_flags         o_flags
);
    import srm_pkg::*;

    localparam int CMP_W = (AGE_BITS > LIMIT_W) ? AGE_BITS : LIMIT_W;

    logic [AGE_BITS-1:0] r_age, n_age, age_cur;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_good, n_good;
    logic                over;
    logic [CMP_W:0]      lim_p1;

    always_comb begin
        age_cur = i_arrived ? '0 : r_age;
        over    = CMP_W'(age_cur) > CMP_W'(i_limit);
        lim_p1  = (CMP_W+1)'(i_limit) + 1'b1;

        n_good            = r_good;
        o_flags.lost      = 1'b0;
        o_flags.recovered = 1'b0;
        if (r_good && over) begin
            n_good       = 1'b0;
            o_flags.lost = 1'b1;
        end else if (!r_good && !over) begin
            n_good            = 1'b1;
            o_flags.recovered = 1'b1;
        end
        o_flags.ok = n_good;

        n_age   = age_cur;
        n_count = r_count + 1'b1;
        if (r_count > i_divider) begin
            // age one step; at saturation jump just past the limit
            if (CMP_W'(age_cur) == CMP_W'(i_sat)) begin
                n_age = AGE_BITS'(lim_p1);
            end else begin
                n_age = age_cur + 1'b1;
            end
            n_count = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age   <= '0;
            r_count <= '0;
            r_good  <= 1'b1;
        end else if (i_accept) begin
            r_age   <= n_age;
            r_count <= n_count;
            r_good  <= n_good;
        end
    end

endmodule

>>> rtl/core/srm_rate.sv
module srm_rate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [srm_pkg::PERIOD_W-1:0]  i_interval,
    input  logic [srm_pkg::PERIOD_W-1:0]  i_period,
    input  logic [srm_pkg::P13_W-1:0]     i_period13,
    output srm_pkg::t_class               o_class,
    output logic                          o_changed
);
    import srm_pkg::*;

    t_class             r_class;
    logic [P13_W-1:0]   d10;
    logic               is_err, is_warn;

    always_comb begin
        d10     = P13_W'({i_interval, 3'b000}) + P13_W'({i_interval, 1'b0});
        is_err  = {1'b0, i_interval} > {i_period, 1'b0};
        // 10*d > 13*T stands for d above 1.3 periods
        is_warn = d10 > i_period13;
        if (is_err) begin
            o_class = CLS_ERROR;
        end else if (is_warn) begin
            o_class = CLS_WARN;
        end else if (i_interval == '0) begin
            o_class = CLS_UNKNOWN;
        end else begin
            o_class = CLS_OK;
        end
        o_changed = (o_class != r_class);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= CLS_UNKNOWN;
        end else if (i_accept) begin
            r_class <= o_class;
        end
    end

endmodule

>>> rtl/core/srm_merge.sv
module srm_merge #(
    parameter int STREAMS = srm_pkg::STREAMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  srm_pkg::t_lane_flags        i_flags [STREAMS],
    input  srm_pkg::t_class             i_class,
    input  logic                        i_changed,
    output logic                        o_in_ready,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [srm_pkg::OUT_W-1:0]   o_tdata
);
    import srm_pkg::*;

    t_out_word word;
    t_out_word r_out, n_out, r_skid, n_skid;
    logic      r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;

    always_comb begin
        word                       = '0;
        word.publish_state         = i_class;
        word.publish_state_changed = i_changed;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < STREAMS) begin
                word.streams_ok[i]        = i_flags[i].ok;
                word.streams_lost[i]      = i_flags[i].lost;
                word.streams_recovered[i] = i_flags[i].recovered;
            end
        end
    end

    // output register plus a skid stage, so input stays open for one stalled word
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (i_tready) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_accept) begin
            if (!r_out_valid || i_tready) begin
                n_out       = word;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = word;
                n_skid_valid = 1'b1;
            end
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_in_ready = !r_skid_valid;
    assign o_tvalid   = r_out_valid;
    assign o_tdata    = r_out;

endmodule

>>> rtl/core/stream_staleness_rate_monitor_top.sv
// Stream staleness and publish rate monitor. Each input word is one monitor
// tick carrying the arrival mask of the watched streams and the last measured
// publish interval; each tick yields exactly one output word with the rate
// class, its change flag and the per-stream ok, lost and recovered bits. One
// lane per stream holds age, tick counter and receiving flag, and a merge stage
// packs the lane flags with the rate class into the output register. A tick is
// taken every cycle while the skid stage is empty: the whole update is one
// compare-and-count step per lane and one 28-bit compare in the rate unit, so
// the output word is registered, and a skid stage keeps the input open for one
// more word while the output is stalled. Configuration goes through the APB
// port at byte addresses 0x00 (period), 0x04 (age limit), 0x08 (saturation),
// 0x0c/0x10/0x14 (dividers); write it only while no tick is in flight.
module stream_staleness_rate_monitor_top #(
    parameter int STREAMS  = srm_pkg::STREAMS_DEF,
    parameter int AGE_BITS = srm_pkg::AGE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [2:0] arrived_mask, [26:3] interval_us, zero fill above
    input  logic [srm_pkg::IN_W-1:0]    i_s_tdata,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [1:0] publish_state, [2] publish_state_changed, [5:3] streams_ok,
    // [8:6] streams_lost, [11:9] streams_recovered, zero fill above
    output logic [srm_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srm_pkg::ADDR_W-1:0]  paddr,
    input  logic [srm_pkg::DATA_W-1:0]  pwdata,
    output logic [srm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import srm_pkg::*;

    logic [PERIOD_W-1:0] r_period;
    logic [P13_W-1:0]    r_period13;
    logic [LIMIT_W-1:0]  r_limit, r_sat;
    logic [DIV_W-1:0]    r_div [NUM_DIV];
    logic [PERIOD_W-1:0] wr_period;
    logic [P13_W-1:0]    wr_period13;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    t_in_word            in_word;
    logic                accept;
    logic                in_ready;
    t_lane_flags         lane_flags [STREAMS];
    t_class              cls;
    logic                cls_changed;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // keep 13*T ready so the rate compare is a single add and compare
    assign wr_period   = pwdata[PERIOD_W-1:0];
    assign wr_period13 = P13_W'({wr_period, 3'b000}) + P13_W'({wr_period, 2'b00})
                       + P13_W'(wr_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RST;
            r_period13 <= PERIOD13_RST;
            r_limit    <= LIMIT_RST;
            r_sat      <= SAT_RST;
            for (int i = 0; i < NUM_DIV; i++) begin
                r_div[i] <= DIV_RST;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PERIOD: begin
                    r_period   <= wr_period;
                    r_period13 <= wr_period13;
                end
                REG_LIMIT:   r_limit  <= pwdata[LIMIT_W-1:0];
                REG_SAT:     r_sat    <= pwdata[LIMIT_W-1:0];
                REG_DIV_SOL: r_div[0] <= pwdata[DIV_W-1:0];
                REG_DIV_IMU: r_div[1] <= pwdata[DIV_W-1:0];
                REG_DIV_DEV: r_div[2] <= pwdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PERIOD:  prdata = DATA_W'(r_period);
            REG_LIMIT:   prdata = DATA_W'(r_limit);
            REG_SAT:     prdata = DATA_W'(r_sat);
            REG_DIV_SOL: prdata = DATA_W'(r_div[0]);
            REG_DIV_IMU: prdata = DATA_W'(r_div[1]);
            REG_DIV_DEV: prdata = DATA_W'(r_div[2]);
            default:     prdata = '0;
        endcase
    end

    assign in_word    = i_s_tdata;
    assign accept     = i_s_tvalid && in_ready;
    assign o_s_tready = in_ready;

    for (genvar g = 0; g < STREAMS; g++) begin : g_lane
        logic             arrived;
        logic [DIV_W-1:0] divider;
        if (g < NUM_DIV) begin : g_io
            assign arrived = in_word.arrived_mask[g];
            assign divider = r_div[g];
        end else begin : g_extra
            // lanes past the input mask never see arrivals and age every tick
            assign arrived = 1'b0;
            assign divider = '0;
        end
        srm_lane #(
            .AGE_BITS (AGE_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (accept),
            .i_arrived (arrived),
            .i_divider (divider),
            .i_limit   (r_limit),
            .i_sat     (r_sat),
            .o_flags   (lane_flags[g])
        );
    end

    srm_rate u_rate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_interval (in_word.interval_us),
        .i_period   (r_period),
        .i_period13 (r_period13),
        .o_class    (cls),
        .o_changed  (cls_changed)
    );

    srm_merge #(
        .STREAMS (STREAMS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_flags    (lane_flags),
        .i_class    (cls),
        .i_changed  (cls_changed),
        .o_in_ready (in_ready),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_tdata    (o_m_tdata)
    );

endmodule

>>> rtl/core/srm_checker.sv
module srm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_s_tready,
    input  logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [srm_pkg::OUT_W-1:0]   o_m_tdata
);
    import srm_pkg::*;

    t_out_word w;
    assign w = o_m_tdata;

    // a stalled word stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // a stream cannot be lost and recovered on the same tick
    a_events_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w.streams_lost & w.streams_recovered) == '0)
        else $error("lost and recovered on the same stream");

    // events must agree with the receiving flags they leave behind
    a_events_vs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((w.streams_lost & w.streams_ok) == '0)
                    && ((w.streams_recovered & ~w.streams_ok) == '0))
        else $error("event bits disagree with ok flags");

    // with a word parked in the skid stage and the output stalled, input is closed
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready && !o_s_tready |=> !o_s_tready || i_m_tready)
        else $error("input reopened with both stages full");

endmodule

bind stream_staleness_rate_monitor_top srm_checker u_srm_checker (.*);

>>> bench/stream_staleness_rate_monitor_top_tb.sv
module stream_staleness_rate_monitor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srm_pkg::*;

    localparam int unsigned ARRIVE_PCT [4] = '{0, 10, 60, 100};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    // [2:0] arrived_mask, [26:3] interval_us, zero fill above
    logic [IN_W-1:0]     i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [1:0] publish_state, [2] publish_state_changed, [5:3] streams_ok,
    // [8:6] streams_lost, [11:9] streams_recovered, zero fill above
    logic [OUT_W-1:0]    o_m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor copy of the registers
    logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;
    logic [LIMIT_W-1:0]  cfg_limit = LIMIT_RST;
    logic [LIMIT_W-1:0]  cfg_sat = SAT_RST;
    logic [DIV_W-1:0]    cfg_div [3] = '{default: DIV_RST};

    // predictor copy of the per-stream lanes and the rate class
    logic [7:0]          lane_age [3] = '{default: '0};
    logic [CNT_W-1:0]    lane_cnt [3] = '{default: '0};
    logic                lane_good [3] = '{default: 1'b1};
    t_class              last_class = CLS_UNKNOWN;

    t_out_word           expected_words [$];
    int                  mismatches = 0;
    int                  words_seen = 0;
    bit                  src_idle_on = 1'b1;
    bit                  sink_idle_on = 1'b1;
    logic                hold_rx = 1'b0;
    int                  stall_left = 0;

    stream_staleness_rate_monitor_top uut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("stream_staleness_rate_monitor_top_tb: done, errors");
        $finish;
    end

    function automatic t_class rate_class_of(logic [PERIOD_W-1:0] d, logic [PERIOD_W-1:0] t);
        logic [31:0] dw, tw;
        dw = 32'(d);
        tw = 32'(t);
        if (dw > tw * 2) return CLS_ERROR;
        if (dw * 10 > tw * 13) return CLS_WARN;
        if (dw == 0) return CLS_UNKNOWN;
        return CLS_OK;
    endfunction

    function automatic t_out_word predict_tick(logic [MASK_W-1:0] mask,
                                               logic [PERIOD_W-1:0] iv);
        t_out_word w;
        t_class    c;
        logic      over;
        int        i;
        w = '0;
        for (i = 0; i < 3; i++)
            if (mask[i]) lane_age[i] = '0;
        c = rate_class_of(iv, cfg_period);
        w.publish_state = c;
        w.publish_state_changed = (c != last_class);
        last_class = c;
        for (i = 0; i < 3; i++) begin
            over = lane_age[i] > cfg_limit;
            if (lane_good[i] && over) begin
                lane_good[i] = 1'b0;
                w.streams_lost[i] = 1'b1;
            end else if (!lane_good[i] && !over) begin
                lane_good[i] = 1'b1;
                w.streams_recovered[i] = 1'b1;
            end
            w.streams_ok[i] = lane_good[i];
            // aging step once the counter has passed the divider
            if (lane_cnt[i] > cfg_div[i]) begin
                if (lane_age[i] == cfg_sat)
                    lane_age[i] = cfg_limit + 8'd1;
                else
                    lane_age[i] = lane_age[i] + 8'd1;
                lane_cnt[i] = '0;
            end
            lane_cnt[i] = lane_cnt[i] + 16'd1;
        end
        return w;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_interval();
        logic [31:0] t, v;
        t = 32'(cfg_period);
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 32'h00FF_FFFF;
            2: v = $urandom_range(0, 32'h00FF_FFFF);
            3: v = (t * 13) / 10 + $urandom_range(0, 2) - 1;  // warning edge
            4: v = t * 2 + $urandom_range(0, 2) - 1;          // error edge
            5: v = $urandom_range(1, t + 1);
            6: v = t;
            default: v = $urandom_range(0, 255);
        endcase
        if (v > 32'h00FF_FFFF) v = 32'h00FF_FFFF;
        return v[PERIOD_W-1:0];
    endfunction

    task automatic note_mismatch(string what);
        if (mismatches < 50) $display("mismatch: word %0d: %s", words_seen, what);
        mismatches++;
    endtask

    task automatic check_word(t_out_word got);
        t_out_word want;
        if (expected_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        want = expected_words.pop_front();
        if (got.publish_state !== want.publish_state)
            note_mismatch($sformatf("publish_state %0d, want %0d",
                                    got.publish_state, want.publish_state));
        if (got.publish_state_changed !== want.publish_state_changed)
            note_mismatch($sformatf("publish_state_changed %b, want %b",
                                    got.publish_state_changed, want.publish_state_changed));
        if (got.streams_ok !== want.streams_ok)
            note_mismatch($sformatf("streams_ok %b, want %b",
                                    got.streams_ok, want.streams_ok));
        if (got.streams_lost !== want.streams_lost)
            note_mismatch($sformatf("streams_lost %b, want %b",
                                    got.streams_lost, want.streams_lost));
        if (got.streams_recovered !== want.streams_recovered)
            note_mismatch($sformatf("streams_recovered %b, want %b",
                                    got.streams_recovered, want.streams_recovered));
        if (got.pad !== '0)
            note_mismatch($sformatf("fill bits %b", got.pad));
    endtask

    // result side: check accepted words, then pick tready for the next cycle
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            check_word(t_out_word'(o_m_tdata));
            words_seen++;
        end
        if (hold_rx) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // called at a rising edge, returns at the edge where the word is taken
    task automatic send_tick(logic [MASK_W-1:0] mask, logic [PERIOD_W-1:0] iv);
        t_in_word w;
        int       gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w = '0;
        w.arrived_mask = mask;
        w.interval_us = iv;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= w;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_words.push_back(predict_tick(mask, iv));
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PERIOD:  cfg_period = val[PERIOD_W-1:0];
            REG_LIMIT:   cfg_limit = val[LIMIT_W-1:0];
            REG_SAT:     cfg_sat = val[LIMIT_W-1:0];
            REG_DIV_SOL: cfg_div[0] = val[DIV_W-1:0];
            REG_DIV_IMU: cfg_div[1] = val[DIV_W-1:0];
            REG_DIV_DEV: cfg_div[2] = val[DIV_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_all(logic [PERIOD_W-1:0] p, logic [7:0] lim, logic [7:0] sat,
                               logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
        settle();
        write_reg(REG_PERIOD, p);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_SAT, sat);
        write_reg(REG_DIV_SOL, d0);
        write_reg(REG_DIV_IMU, d1);
        write_reg(REG_DIV_DEV, d2);
    endtask

    task automatic program_random();
        logic [PERIOD_W-1:0] p;
        logic [7:0]          lim, sat;
        logic [15:0]         dv [3];
        int                  i;
        case ($urandom_range(0, 3))
            0: p = PERIOD_W'($urandom_range(1, 200));
            1: p = PERIOD_W'($urandom_range(200, 50000));
            2: p = PERIOD_W'($urandom_range(0, 32'h00FF_FFFF));
            default: p = 24'd10000;
        endcase
        lim = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 12));
        sat = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : lim + 8'($urandom_range(0, 5));
        for (i = 0; i < 3; i++)
            dv[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 3));
        program_all(p, lim, sat, dv[0], dv[1], dv[2]);
    endtask

    // per burst each stream gets its own arrival rate, from silent to always
    task automatic send_burst(int n);
        int               lvl [3];
        int               i, k;
        logic [MASK_W-1:0] m;
        for (i = 0; i < 3; i++) lvl[i] = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            for (i = 0; i < 3; i++) m[i] = ($urandom_range(0, 99) < ARRIVE_PCT[lvl[i]]);
            send_tick(m, pick_interval());
        end
    endtask

    task automatic test_reset_config_directed();
        int k;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        send_tick(3'b000, 24'd0);
        send_tick(3'b000, 24'd1);
        send_tick(3'b111, 24'd13000);
        send_tick(3'b111, 24'd13001);
        send_tick(3'b111, 24'd20000);
        send_tick(3'b111, 24'd20001);
        send_tick(3'b111, 24'hFF_FFFF);
        send_tick(3'b111, 24'd0);
        // silence until every stream goes missing
        for (k = 0; k < 12; k++) send_tick(3'b000, 24'd10000);
        send_tick(3'b001, 24'd9999);
        send_tick(3'b010, 24'd9999);
        send_tick(3'b100, 24'd9999);
        send_tick(3'b111, 24'd10000);
        settle();
    endtask

    task automatic test_register_extremes();
        program_all(24'd0, 8'd0, 8'd1, 16'd0, 16'd65535, 16'd65534);
        send_burst(24);
        program_all(24'd1, 8'd255, 8'd0, 16'd1, 16'd0, 16'd2);
        send_burst(24);
        program_all(24'hFF_FFFF, 8'd254, 8'd255, 16'd65534, 16'd65535, 16'd0);
        send_burst(24);
        program_all(24'd10000, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        send_burst(24);
        settle();
    endtask

    // saturation below the jump target: age climbs past it and wraps at 256
    task automatic test_age_wrap();
        int k;
        program_all(24'd5000, 8'd5, 8'd3, 16'd0, 16'd1, 16'd0);
        send_tick(3'b111, 24'd5000);
        for (k = 0; k < 300; k++) send_tick(3'b000, pick_interval());
        send_tick(3'b111, 24'd5000);
        settle();
    endtask

    task automatic test_random_phases();
        int ph, b;
        for (ph = 0; ph < 10; ph++) begin
            program_random();
            for (b = 0; b < 4; b++) begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
                send_burst($urandom_range(10, 30));
            end
        end
        settle();
    endtask

    task automatic test_output_backpressure();
        int k;
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        for (k = 0; k < 30; k++) send_tick(3'($urandom_range(0, 7)), pick_interval());
        settle();
    endtask

    task automatic test_steady_stream();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        program_random();
        send_burst(50);
        send_burst(50);
        settle();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config_directed();
        test_register_extremes();
        test_age_wrap();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("stream_staleness_rate_monitor_top_tb: done, clean");
        else
            $display("stream_staleness_rate_monitor_top_tb: done, errors");
        $finish;
    end

endmodule
